### rtl/spq_pkg.sv
package spq_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam int DATA_BITS = 32;
   localparam int PRIO_BITS = 16;
   localparam int OCC_BITS  = 5;

   // controller states
   typedef enum logic {
      ST_OPEN,
      ST_HOLD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       ins;
      logic       rem;
      logic       load;
      status_type rsp_status;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
   } dp_stat_type;

endpackage

### rtl/spq_ctrl.sv
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output ctrl_type    ctrl
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_OPEN;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b0;
      rsp_valid       = 1'b0;
      ctrl.ins        = 1'b0;
      ctrl.rem        = 1'b0;
      ctrl.load       = 1'b0;
      ctrl.rsp_status = STATUS_DONE;
      accept          = 1'b0;
      case (state_ff)
         ST_OPEN: begin
            accept = req_valid;
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            accept    = req_valid && !rsp_stall;
            if (!rsp_stall) begin
               state_in = ST_OPEN;
            end
         end
         default: begin
            state_in = ST_OPEN;
         end
      endcase
      if (accept) begin
         state_in  = ST_HOLD;
         ctrl.load = 1'b1;
         if (req_cmd == CMD_INSERT) begin
            if (stat.full) begin
               ctrl.rsp_status = STATUS_FULL;
            end else begin
               ctrl.ins = 1'b1;
            end
         end else begin
            if (stat.empty) begin
               ctrl.rsp_status = STATUS_EMPTY;
            end else begin
               ctrl.rem = 1'b1;
            end
         end
      end
   end

endmodule

### rtl/spq_cells.sv
module spq_cells
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_type                    ctrl,
   output dp_stat_type                 stat,
   input  logic [DATA_BITS-1:0]        req_item_value,
   input  logic signed [PRIO_BITS-1:0] req_priority_req,
   output logic [DATA_BITS-1:0]        rsp_out_value,
   output logic [1:0]                  rsp_status,
   output logic [OCC_BITS-1:0]         rsp_occupancy
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int WW = (VALUE_WIDTH > DATA_BITS) ? VALUE_WIDTH : DATA_BITS;
   localparam int OW = (CW > OCC_BITS) ? CW : OCC_BITS;

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic [VALUE_WIDTH-1:0]       val_ff [QUEUE_DEPTH];
   logic signed [PRIO_BITS-1:0]  prio_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]       gt;
   logic [WW-1:0]                in_wide;
   logic [WW-1:0]                head_wide;
   logic [VALUE_WIDTH-1:0]       new_val;
   logic [OW-1:0]                occ_wide;
   logic [DATA_BITS-1:0]         value_ff;
   logic [1:0]                   status_ff;
   logic [OCC_BITS-1:0]          occ_ff;

   // value width adaption
   assign in_wide   = WW'(req_item_value);
   assign new_val   = in_wide[VALUE_WIDTH-1:0];
   assign head_wide = WW'(val_ff[0]);

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(QUEUE_DEPTH));

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of cells: compare, then shift right on insert or left on remove
   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         assign gt[i] = (CW'(i) >= count_ff) || (req_priority_req > prio_ff[i]);

         if (i == 0) begin : g_head
            always_ff @(posedge clock) begin
               if (ctrl.ins && gt[i]) begin
                  val_ff[i]  <= new_val;
                  prio_ff[i] <= req_priority_req;
               end else if (ctrl.rem && (QUEUE_DEPTH > 1)) begin
                  val_ff[i]  <= val_ff[1];
                  prio_ff[i] <= prio_ff[1];
               end
            end
         end else if (i == QUEUE_DEPTH - 1) begin : g_tail
            always_ff @(posedge clock) begin
               if (ctrl.ins && gt[i] && !gt[i-1]) begin
                  val_ff[i]  <= new_val;
                  prio_ff[i] <= req_priority_req;
               end else if (ctrl.ins && gt[i-1]) begin
                  val_ff[i]  <= val_ff[i-1];
                  prio_ff[i] <= prio_ff[i-1];
               end
            end
         end else begin : g_mid
            always_ff @(posedge clock) begin
               if (ctrl.ins && gt[i] && !gt[i-1]) begin
                  val_ff[i]  <= new_val;
                  prio_ff[i] <= req_priority_req;
               end else if (ctrl.ins && gt[i-1]) begin
                  val_ff[i]  <= val_ff[i-1];
                  prio_ff[i] <= prio_ff[i-1];
               end else if (ctrl.rem) begin
                  val_ff[i]  <= val_ff[i+1];
                  prio_ff[i] <= prio_ff[i+1];
               end
            end
         end
      end
   endgenerate

   // response word
   assign occ_wide = OW'(count_in);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff  <= ctrl.rem ? head_wide[DATA_BITS-1:0] : '0;
         status_ff <= ctrl.rsp_status;
         occ_ff    <= occ_wide[OCC_BITS-1:0];
      end
   end

   assign rsp_out_value = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

endmodule

### rtl/stable_priority_queue_core.sv
// Bounded priority queue of value and signed priority pairs, highest
// priority at the head, equal priorities served in arrival order. A req
// word with cmd 0 inserts, cmd 1 removes the head; each req word yields one
// rsp word with the removed value (zero otherwise), a status (done, remove
// on empty, insert dropped when full) and the occupancy after the command.
// Each entry sits in its own cell, all cells compare the new priority
// against their own at once and shift in a single step, so a new req word
// is taken in the cycle its predecessor's rsp word is taken, and a held rsp
// word stalls the req side only while rsp_stall is high. Entries reset
// empty; no clearing pass is needed.
module stable_priority_queue_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_cmd,
   input  logic [DATA_BITS-1:0]        req_item_value,
   input  logic signed [PRIO_BITS-1:0] req_priority_req,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [DATA_BITS-1:0]        rsp_out_value,
   output logic [1:0]                  rsp_status,
   output logic [OCC_BITS-1:0]         rsp_occupancy
);

   ctrl_type    ctrl;
   dp_stat_type stat;

   // sequencer
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // sorted cell row and response register
   spq_cells #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_cells (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_item_value   (req_item_value),
      .req_priority_req (req_priority_req),
      .rsp_out_value    (rsp_out_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
